// ===== design/htfc_pkg.sv =====
// Shared widths, constants, status codes and the CRC-8 byte step for the frame checker.
package htfc_pkg;

  // Field widths.
  localparam int WORD_W  = 16;
  localparam int CHECK_W = 8;
  localparam int OFS_W   = 12;
  localparam int TEMP_W  = 15;
  localparam int HUM_W   = 14;
  localparam int STAT_W  = 2;

  // Register indexes on the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_OFFSET  = 1'd1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUS = 2'd1;
  localparam logic [STAT_W-1:0] ST_CRC = 2'd2;

  // CRC-8 parameters.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Conversion constants.
  localparam logic [14:0] TEMP_SPAN = 15'd17500;
  localparam logic [13:0] HUM_SPAN  = 14'd10000;
  localparam logic [16:0] RAW_FULL  = 17'd65535;
  localparam logic signed [15:0] TEMP_BASE = -16'sd4500;
  localparam logic signed [15:0] HUM_MAX   = 16'sd10000;

  // One byte through the CRC-8 shift register, most significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== design/htfc_in_if.sv =====
// Input channel carrying one sensor read frame per transfer.
interface htfc_in_if import htfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  temp_word;
  logic [CHECK_W-1:0] temp_check;
  logic [WORD_W-1:0]  hum_word;
  logic [CHECK_W-1:0] hum_check;
  logic               bus_fail;

  modport source (output valid, temp_word, temp_check, hum_word, hum_check, bus_fail,
                  input ready);
  modport sink (input valid, temp_word, temp_check, hum_word, hum_check, bus_fail,
                output ready);
endinterface

// ===== design/htfc_out_if.sv =====
// Result channel carrying one converted reading and its status per transfer.
interface htfc_out_if import htfc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic [HUM_W-1:0]         humidity;
  logic [STAT_W-1:0]        status;

  modport source (output valid, temperature, humidity, status, input ready);
  modport sink (input valid, temperature, humidity, status, output ready);
endinterface

// ===== design/humidity_temp_frame_checker_core.sv =====
// A frame passes stages 1, 2 and 3 in order before its result is offered.
// Throughput: one frame per cycle while results are taken; each of the three stages
// holds one frame and moves on whenever the stage after it is empty or moving.
// Stage 1 runs the multipliers and the high CRC byte, stage 2 the low CRC
// byte and the divide by 65535, stage 3 the offsets, clamp and status.
// Reset (rst_n low, synchronous) empties the pipeline and zeroes both offsets.
module humidity_temp_frame_checker_core import htfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  htfc_in_if.sink              in_chan,
  htfc_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFS_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [OFS_W-1:0] temp_offset_r;
  logic [OFS_W-1:0] hum_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_offset_r <= '0;
      hum_offset_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP_OFFSET: temp_offset_r <= cfg_wdata;
        CFG_HUM_OFFSET:  hum_offset_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-stage flow control: a stage loads when it is empty or its contents move on.
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready      = !out_valid_r || out_chan.ready;
  assign s2_ready      = !s2_valid_r || s3_ready;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign in_chan.ready = s1_ready;

  // Stage 1: scale both raw words and run the high byte of each CRC.
  logic              s1_bus_fail_r;
  logic [30:0]       s1_t_prod_r;
  logic [29:0]       s1_h_prod_r;
  logic [7:0]        s1_t_crc_r, s1_h_crc_r;
  logic [7:0]        s1_t_lo_r, s1_h_lo_r;
  logic [CHECK_W-1:0] s1_t_chk_r, s1_h_chk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_bus_fail_r <= in_chan.bus_fail;
      s1_t_prod_r   <= 31'(in_chan.temp_word) * 31'(TEMP_SPAN);
      s1_h_prod_r   <= 30'(in_chan.hum_word) * 30'(HUM_SPAN);
      s1_t_crc_r    <= crc8_byte(CRC_INIT, in_chan.temp_word[15:8]);
      s1_h_crc_r    <= crc8_byte(CRC_INIT, in_chan.hum_word[15:8]);
      s1_t_lo_r     <= in_chan.temp_word[7:0];
      s1_h_lo_r     <= in_chan.hum_word[7:0];
      s1_t_chk_r    <= in_chan.temp_check;
      s1_h_chk_r    <= in_chan.hum_check;
    end
  end

  // Stage 2: finish the CRCs and divide by 65535.
  // With q = p >> 16 the remainder is low16 + q, which stays below twice the
  // divisor, so a single compare corrects the quotient.
  logic [14:0] t_qe, t_q_nxt;
  logic [13:0] h_qe, h_q_nxt;
  logic [16:0] t_rem, h_rem;
  logic        crc_bad_nxt;

  always_comb begin
    t_qe    = s1_t_prod_r[30:16];
    t_rem   = 17'(s1_t_prod_r[15:0]) + 17'(t_qe);
    t_q_nxt = t_qe + 15'(t_rem >= RAW_FULL);
    h_qe    = s1_h_prod_r[29:16];
    h_rem   = 17'(s1_h_prod_r[15:0]) + 17'(h_qe);
    h_q_nxt = h_qe + 14'(h_rem >= RAW_FULL);
    crc_bad_nxt = (crc8_byte(s1_t_crc_r, s1_t_lo_r) != s1_t_chk_r)
               || (crc8_byte(s1_h_crc_r, s1_h_lo_r) != s1_h_chk_r);
  end

  logic        s2_bus_fail_r;
  logic        s2_crc_bad_r;
  logic [14:0] s2_t_q_r;
  logic [13:0] s2_h_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_bus_fail_r <= s1_bus_fail_r;
      s2_crc_bad_r  <= crc_bad_nxt;
      s2_t_q_r      <= t_q_nxt;
      s2_h_q_r      <= h_q_nxt;
    end
  end

  // Stage 3: apply offsets, clamp humidity and pick the status.
  logic signed [15:0]       t_sum, h_sum;
  logic signed [TEMP_W-1:0] temp_nxt;
  logic [HUM_W-1:0]         hum_nxt;
  logic [STAT_W-1:0]        status_nxt;

  always_comb begin
    t_sum = TEMP_BASE + $signed({1'b0, s2_t_q_r})
          + $signed({{(16-OFS_W){temp_offset_r[OFS_W-1]}}, temp_offset_r});
    h_sum = $signed({2'b00, s2_h_q_r})
          + $signed({{(16-OFS_W){hum_offset_r[OFS_W-1]}}, hum_offset_r});
    temp_nxt   = '0;
    hum_nxt    = '0;
    status_nxt = ST_OK;
    priority if (s2_bus_fail_r) begin
      status_nxt = ST_BUS;
    end else if (s2_crc_bad_r) begin
      status_nxt = ST_CRC;
    end else begin
      temp_nxt = t_sum[TEMP_W-1:0];
      priority if (h_sum < 0) begin
        hum_nxt = '0;
      end else if (h_sum > HUM_MAX) begin
        hum_nxt = HUM_MAX[HUM_W-1:0];
      end else begin
        hum_nxt = h_sum[HUM_W-1:0];
      end
    end
  end

  logic signed [TEMP_W-1:0] out_temp_r;
  logic [HUM_W-1:0]         out_hum_r;
  logic [STAT_W-1:0]        out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      out_temp_r   <= temp_nxt;
      out_hum_r    <= hum_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.temperature = out_temp_r;
  assign out_chan.humidity    = out_hum_r;
  assign out_chan.status      = out_status_r;

  // A failed frame carries zero readings.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_temp_r == '0) && (out_hum_r == '0))
    else $error("error result carries nonzero readings");

  // Humidity never leaves its clamped range.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_hum_r <= HUM_MAX[HUM_W-1:0])
    else $error("humidity above full scale");

  // A stalled stage-1 frame is not dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r)
    else $error("stage 1 frame lost during stall");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result offered right after reset");

endmodule

// ===== tb/sv/htfc_reading_checker.sv =====
// Watches both channels of the frame checker, predicts each reading and compares it.
`timescale 1ns / 100ps

module htfc_reading_checker import htfc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  htfc_in_if                   in_mon,
  htfc_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFS_W-1:0]     cfg_wdata,
  output int                   pending,
  output int                   mismatches
);

  localparam int TEMP_ZERO  = -4500;
  localparam int TEMP_RANGE = 17500;
  localparam int HUM_RANGE  = 10000;
  localparam int RAW_MAX    = 65535;
  localparam int HUM_LIMIT  = 10000;
  localparam int PRINT_MAX  = 40;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic [STAT_W-1:0]        status;
  } reading_t;

  logic signed [OFS_W-1:0] temp_ofs;
  logic signed [OFS_W-1:0] hum_ofs;
  reading_t                expected_readings[$];
  int                      results_seen;

  initial begin
    pending      = 0;
    mismatches   = 0;
    results_seen = 0;
    temp_ofs     = '0;
    hum_ofs      = '0;
  end

  // CRC-8 of one word, fed one bit at a time from the most significant end.
  function automatic logic [7:0] word_crc(input logic [WORD_W-1:0] word);
    logic [7:0] rem;
    logic       fb;
    rem = CRC_INIT;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      fb  = rem[7] ^ word[i];
      rem = {rem[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return rem;
  endfunction

  // Status and converted reading for one frame under the current offsets.
  function automatic reading_t predict_reading(input logic [WORD_W-1:0] tw,
                                               input logic [CHECK_W-1:0] tc,
                                               input logic [WORD_W-1:0] hw,
                                               input logic [CHECK_W-1:0] hc,
                                               input logic bf);
    reading_t r;
    int       t;
    int       h;
    r = '0;
    if (bf) begin
      r.status = ST_BUS;
    end else if (word_crc(tw) != tc || word_crc(hw) != hc) begin
      r.status = ST_CRC;
    end else begin
      t = TEMP_ZERO + (TEMP_RANGE * int'(tw)) / RAW_MAX + int'(temp_ofs);
      h = (HUM_RANGE * int'(hw)) / RAW_MAX + int'(hum_ofs);
      if (h < 0) h = 0;
      if (h > HUM_LIMIT) h = HUM_LIMIT;
      r.temperature = t[TEMP_W-1:0];
      r.humidity    = h[HUM_W-1:0];
      r.status      = ST_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_MAX) begin
      $display("MISMATCH at result %0d: %s", results_seen, what);
    end
    mismatches++;
  endtask

  // Track offset writes, queue a prediction per input transfer and check each result transfer.
  always @(posedge clk) begin : track
    reading_t want;
    int       pushed;
    int       popped;
    pushed = 0;
    popped = 0;
    if (!rst_n) begin
      temp_ofs <= '0;
      hum_ofs  <= '0;
      expected_readings.delete();
      pending  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEMP_OFFSET: temp_ofs <= cfg_wdata;
          CFG_HUM_OFFSET:  hum_ofs  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_readings.push_back(predict_reading(in_mon.temp_word, in_mon.temp_check,
                                                    in_mon.hum_word, in_mon.hum_check,
                                                    in_mon.bus_fail));
        pushed = 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result with no frame waiting (status %0d)",
                                    out_mon.status));
        end else begin
          want   = expected_readings.pop_front();
          popped = 1;
          if (out_mon.temperature !== want.temperature) begin
            report_mismatch($sformatf("temperature got %0d, expected %0d",
                                      out_mon.temperature, want.temperature));
          end
          if (out_mon.humidity !== want.humidity) begin
            report_mismatch($sformatf("humidity got %0d, expected %0d",
                                      out_mon.humidity, want.humidity));
          end
          if (out_mon.status !== want.status) begin
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      out_mon.status, want.status));
          end
        end
        results_seen++;
      end
      pending <= pending + pushed - popped;
    end
  end

endmodule

// ===== tb/sv/tb_humidity_temp_frame_checker_core.sv =====
// Top of the frame checker testbench: clock, reset, frame stimulus, offset writes and verdict.
`timescale 1ns / 100ps

module tb_humidity_temp_frame_checker_core import htfc_pkg::*; ();

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 7;
  localparam int PHASE_FRAMES = 280;
  localparam int HOLD_CYCLES  = 160;
  localparam int SETTLE       = 8;

  typedef struct packed {
    logic [WORD_W-1:0]  temp_word;
    logic [CHECK_W-1:0] temp_check;
    logic [WORD_W-1:0]  hum_word;
    logic [CHECK_W-1:0] hum_check;
    logic               bus_fail;
  } frame_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [OFS_W-1:0]     cfg_wdata;
  int                   pending;
  int                   mismatches;
  bit                   idle_en = 1'b1;
  int                   hold_asked = 0;

  htfc_in_if  in_chan ();
  htfc_out_if out_chan ();

  humidity_temp_frame_checker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  htfc_reading_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Check byte the sensor would send for a word.
  function automatic logic [7:0] word_check(input logic [WORD_W-1:0] w);
    return crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  function automatic frame_t good_frame(input logic [WORD_W-1:0] tw, input logic [WORD_W-1:0] hw);
    frame_t f;
    f.temp_word  = tw;
    f.temp_check = word_check(tw);
    f.hum_word   = hw;
    f.hum_check  = word_check(hw);
    f.bus_fail   = 1'b0;
    return f;
  endfunction

  // Raw words lean toward the ends of the range so that clamping gets exercised.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 300));
      3:       return 16'($urandom_range(65235, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames; the rest carry a bus failure or a corrupted check byte.
  function automatic frame_t random_frame();
    frame_t f;
    int     kind;
    f    = good_frame(pick_word(), pick_word());
    kind = $urandom_range(99);
    if (kind >= 90) begin
      f.hum_check ^= 8'($urandom_range(1, 255));
    end else if (kind >= 80) begin
      f.temp_check ^= 8'($urandom_range(1, 255));
    end else if (kind >= 70) begin
      f.bus_fail = 1'b1;
      if ($urandom_range(1)) begin
        f.temp_check = 8'($urandom);
        f.hum_check  = 8'($urandom);
      end
    end
    return f;
  endfunction

  // Offer one frame and return at the edge where its transfer happens.
  task automatic send_frame(input frame_t f);
    if (idle_en && $urandom_range(99) < 3) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.temp_word  <= f.temp_word;
    in_chan.temp_check <= f.temp_check;
    in_chan.hum_word   <= f.hum_word;
    in_chan.hum_check  <= f.hum_check;
    in_chan.bus_fail   <= f.bus_fail;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every frame has produced its reading.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [OFS_W-1:0] t_ofs, input logic [OFS_W-1:0] h_ofs);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TEMP_OFFSET;
    cfg_wdata <= t_ofs;
    @(posedge clk);
    cfg_index <= CFG_HUM_OFFSET;
    cfg_wdata <= h_ofs;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (PHASE_FRAMES) send_frame(random_frame());
  endtask

  // Result side: random stalls, plus one long hold-off whenever one is asked for.
  initial begin : sink
    int hold_done;
    hold_done      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done < hold_asked) begin
        hold_done++;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_chan.ready <= !(idle_en && $urandom_range(99) < 6);
      end
    end
  end

  initial begin : stimulus
    frame_t f;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_TEMP_OFFSET;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.temp_word  = '0;
    in_chan.temp_check = '0;
    in_chan.hum_word   = '0;
    in_chan.hum_check  = '0;
    in_chan.bus_fail   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset offsets: word extremes and every status.
    send_frame(good_frame(16'h0000, 16'h0000));
    send_frame(good_frame(16'hFFFF, 16'hFFFF));
    send_frame(good_frame(16'h8000, 16'h8000));
    send_frame(good_frame(16'h7FFF, 16'h0001));
    send_frame(good_frame(16'hFFFE, 16'hFFFE));
    send_frame(good_frame(16'hAAAA, 16'h5555));
    send_frame(good_frame(16'h5555, 16'hAAAA));
    // A bus failure wins whether the check bytes are right or wrong.
    f = good_frame(16'h6666, 16'h9999);
    f.bus_fail = 1'b1;
    send_frame(f);
    f.temp_check ^= 8'hFF;
    f.hum_check  ^= 8'h01;
    send_frame(f);
    // Check byte mismatches on either word and on both.
    f = good_frame(16'h1234, 16'hBEEF);
    f.temp_check ^= 8'h01;
    send_frame(f);
    f = good_frame(16'h1234, 16'hBEEF);
    f.hum_check ^= 8'h80;
    send_frame(f);
    f = good_frame(16'hFFFF, 16'h0000);
    f.temp_check = ~f.temp_check;
    f.hum_check  = ~f.hum_check;
    send_frame(f);
    f = good_frame(16'h0000, 16'hFFFF);
    f.temp_check = 8'h00;
    f.hum_check  = 8'hFF;
    send_frame(f);

    // Random frames at reset offsets, with one long hold-off on the result side midway.
    repeat (PHASE_FRAMES / 2) send_frame(random_frame());
    hold_asked <= hold_asked + 1;
    repeat (PHASE_FRAMES / 2) send_frame(random_frame());

    run_phase(12'sd2047, 12'sd2047);
    idle_en <= 1'b0;
    run_phase(-12'sd2048, -12'sd2048);
    idle_en <= 1'b1;
    run_phase(12'sd2000, -12'sd2000);
    run_phase(-12'sd2000, 12'sd2000);
    run_phase(12'($urandom), 12'($urandom));

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit far beyond the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
design/htfc_pkg.sv
design/htfc_in_if.sv
design/htfc_out_if.sv
design/humidity_temp_frame_checker_core.sv
tb/sv/htfc_reading_checker.sv
tb/sv/tb_humidity_temp_frame_checker_core.sv
